@@ rtl/lssm_pkg.sv @@
// lssm_pkg: types, codes and helper functions for the link session controller
// shared by lssm_core, link_session_state_machine_unit and lssm_checker; no dependencies
`default_nettype none

package lssm_pkg;

   // command codes of an input item
   typedef enum logic [2:0] {
      CMD_TICK       = 3'd0,
      CMD_FRAME      = 3'd1,
      CMD_START_DL   = 3'd2,
      CMD_ABORT      = 3'd3,
      CMD_RESET      = 3'd4,
      CMD_UL_OFFERED = 3'd5,
      CMD_QUERY      = 3'd6,
      CMD_SPARE      = 3'd7
   } cmd_type;

   // session phase, one-hot
   typedef enum logic [8:0] {
      PH_IDLE    = 9'b000000001,
      PH_WAITREQ = 9'b000000010,
      PH_DLBUSY  = 9'b000000100,
      PH_DLDONE  = 9'b000001000,
      PH_ULOFFER = 9'b000010000,
      PH_ULBUSY  = 9'b000100000,
      PH_ULDONE  = 9'b001000000,
      PH_ABORTED = 9'b010000000,
      PH_ERROR   = 9'b100000000
   } phase_type;

   // what the session is waiting for, one-hot
   typedef enum logic [4:0] {
      WK_NONE    = 5'b00001,
      WK_REQ     = 5'b00010,
      WK_DLCONF  = 5'b00100,
      WK_ULHDR   = 5'b01000,
      WK_ULPARTS = 5'b10000
   } wait_kind_type;

   // reported session state codes
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_WAITREQ = 4'd1;
   localparam logic [3:0] ST_DLBUSY  = 4'd2;
   localparam logic [3:0] ST_DLDONE  = 4'd3;
   localparam logic [3:0] ST_ULOFFER = 4'd4;
   localparam logic [3:0] ST_ULBUSY  = 4'd5;
   localparam logic [3:0] ST_ULDONE  = 4'd6;
   localparam logic [3:0] ST_ABORTED = 4'd7;
   localparam logic [3:0] ST_ERROR   = 4'd8;

   // event codes
   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_TIMEOUT    = 3'd1;
   localparam logic [2:0] EV_STATUS_ERR = 3'd2;
   localparam logic [2:0] EV_HEADER_ERR = 3'd3;
   localparam logic [2:0] EV_UNEXP_HDR  = 3'd4;
   localparam logic [2:0] EV_UL_DONE    = 3'd5;

   // frame type ids
   localparam logic [7:0] TY_REQ_TX     = 8'd3;
   localparam logic [7:0] TY_HEADER     = 8'd5;
   localparam logic [7:0] TY_PART_REQ   = 8'd7;
   localparam logic [7:0] TY_PART       = 8'd9;
   localparam logic [7:0] TY_PART_CONF  = 8'd10;
   localparam logic [7:0] TY_MSG_CONF   = 8'd11;
   localparam logic [7:0] TY_STATUS_UPD = 8'd13;

   // configuration register indexes and reset values
   localparam logic CSR_TIMEOUT   = 1'b0;
   localparam logic CSR_MAX_RETRY = 1'b1;
   localparam logic [31:0] TIMEOUT_RESET   = 32'd2000;
   localparam logic [3:0]  MAX_RETRY_RESET = 4'd3;

   // one input item
   typedef struct packed {
      cmd_type     command;
      logic [31:0] now_ms;
      logic [7:0]  rx_type;
      logic [7:0]  rx_status;
      logic [31:0] message_id;
      logic        uplink_message_complete;
   } item_type;

   // session context
   typedef struct packed {
      phase_type     phase;
      wait_kind_type wait_kind;
      logic [3:0]    retry_count;
      logic [31:0]   wait_start;
      logic          frame_pending;
      logic [7:0]    last_type;
      logic [7:0]    last_status;
      logic [31:0]   last_frame_id;
      logic [31:0]   downlink_id;
   } ctx_type;

   // context after reset or a reset command
   function automatic ctx_type ctx_clear();
      ctx_type c;
      c.phase         = PH_IDLE;
      c.wait_kind     = WK_NONE;
      c.retry_count   = 4'd0;
      c.wait_start    = 32'd0;
      c.frame_pending = 1'b0;
      c.last_type     = 8'd0;
      c.last_status   = 8'd0;
      c.last_frame_id = 32'd0;
      c.downlink_id   = 32'd0;
      return c;
   endfunction

   // enter a new wait: drop frame history, restart timer and retries
   function automatic ctx_type begin_wait(ctx_type c, wait_kind_type kind,
                                          logic [31:0] now);
      ctx_type r;
      r               = c;
      r.wait_kind     = kind;
      r.retry_count   = 4'd0;
      r.frame_pending = 1'b0;
      r.last_type     = 8'd0;
      r.last_status   = 8'd0;
      r.last_frame_id = 32'd0;
      r.wait_start    = now;
      return r;
   endfunction

   // one-hot phase to reported code
   function automatic logic [3:0] phase_code(phase_type ph);
      logic [3:0] code;
      case (ph)
         PH_IDLE:    code = ST_IDLE;
         PH_WAITREQ: code = ST_WAITREQ;
         PH_DLBUSY:  code = ST_DLBUSY;
         PH_DLDONE:  code = ST_DLDONE;
         PH_ULOFFER: code = ST_ULOFFER;
         PH_ULBUSY:  code = ST_ULBUSY;
         PH_ULDONE:  code = ST_ULDONE;
         PH_ABORTED: code = ST_ABORTED;
         PH_ERROR:   code = ST_ERROR;
         default:    code = ST_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lssm_core.sv @@
// lssm_core: next session context and event code for one item
// uses lssm_pkg; purely combinational, registered by the top level
`default_nettype none

module lssm_core (
   input  wire lssm_pkg::ctx_type  cur,
   input  wire lssm_pkg::item_type item,
   input  wire logic [31:0]        timeout_ms,
   input  wire logic [3:0]         max_retry,
   output lssm_pkg::ctx_type       nxt,
   output logic [2:0]              event_code
);

   logic [31:0] elapsed;
   logic        timed_out;
   logic        can_retry;
   logic        do_timer;
   logic        status_bad;
   logic        id_match;

   // timer and retry checks
   assign elapsed    = item.now_ms - cur.wait_start;
   assign timed_out  = (elapsed >= timeout_ms);
   assign can_retry  = (cur.retry_count < max_retry);
   assign status_bad = (cur.last_status != 8'd0);
   assign id_match   = (cur.downlink_id == 32'd0) || (cur.last_frame_id == 32'd0) ||
                       (cur.last_frame_id == cur.downlink_id);

   // command decode and session transitions
   always_comb begin
      nxt        = cur;
      event_code = lssm_pkg::EV_NONE;
      do_timer   = 1'b0;
      case (item.command)
         lssm_pkg::CMD_TICK: begin
            case (cur.phase)
               lssm_pkg::PH_WAITREQ: begin
                  if (cur.wait_kind == lssm_pkg::WK_REQ) begin
                     if (!cur.frame_pending) begin
                        do_timer = 1'b1;
                     end else begin
                        nxt.frame_pending = 1'b0;
                        if (cur.last_type == lssm_pkg::TY_REQ_TX && !status_bad) begin
                           nxt = lssm_pkg::begin_wait(nxt, lssm_pkg::WK_DLCONF,
                                                      item.now_ms);
                           nxt.phase = lssm_pkg::PH_DLBUSY;
                        end else if (status_bad) begin
                           nxt.wait_kind = lssm_pkg::WK_NONE;
                           nxt.phase     = lssm_pkg::PH_ERROR;
                        end
                     end
                  end
               end
               lssm_pkg::PH_DLBUSY: begin
                  if (cur.wait_kind == lssm_pkg::WK_DLCONF) begin
                     if (!cur.frame_pending) begin
                        do_timer = 1'b1;
                     end else begin
                        nxt.frame_pending = 1'b0;
                        if (status_bad) begin
                           if (cur.last_type != lssm_pkg::TY_PART_CONF) begin
                              nxt.wait_kind = lssm_pkg::WK_NONE;
                              nxt.phase     = lssm_pkg::PH_ERROR;
                              if (cur.last_type == lssm_pkg::TY_STATUS_UPD) begin
                                 event_code = lssm_pkg::EV_STATUS_ERR;
                              end
                           end else begin
                              nxt.wait_start = item.now_ms;
                           end
                        end else if (cur.last_type == lssm_pkg::TY_MSG_CONF) begin
                           if (id_match) begin
                              nxt.wait_kind = lssm_pkg::WK_NONE;
                              nxt.phase     = lssm_pkg::PH_DLDONE;
                           end else begin
                              nxt.wait_start = item.now_ms;
                           end
                        end else if (cur.last_type == lssm_pkg::TY_PART_REQ ||
                                     cur.last_type == lssm_pkg::TY_PART_CONF ||
                                     cur.last_type == lssm_pkg::TY_STATUS_UPD) begin
                           nxt.wait_start = item.now_ms;
                        end
                     end
                  end
               end
               lssm_pkg::PH_DLDONE, lssm_pkg::PH_ULDONE: begin
                  nxt.phase = lssm_pkg::PH_IDLE;
               end
               lssm_pkg::PH_ULOFFER: begin
                  if (cur.wait_kind == lssm_pkg::WK_ULHDR) begin
                     if (!cur.frame_pending) begin
                        do_timer = 1'b1;
                     end else begin
                        nxt.frame_pending = 1'b0;
                        if (cur.last_type == lssm_pkg::TY_HEADER && !status_bad) begin
                           nxt = lssm_pkg::begin_wait(nxt, lssm_pkg::WK_ULPARTS,
                                                      item.now_ms);
                           nxt.phase = lssm_pkg::PH_ULBUSY;
                        end else if (status_bad) begin
                           nxt.wait_kind = lssm_pkg::WK_NONE;
                           nxt.phase     = lssm_pkg::PH_ERROR;
                           event_code    = lssm_pkg::EV_HEADER_ERR;
                        end
                     end
                  end
               end
               lssm_pkg::PH_ULBUSY: begin
                  if (cur.wait_kind == lssm_pkg::WK_ULPARTS) begin
                     if (!cur.frame_pending) begin
                        do_timer = 1'b1;
                     end else begin
                        nxt.frame_pending = 1'b0;
                        if (cur.last_type == lssm_pkg::TY_PART) begin
                           if (status_bad) begin
                              nxt.wait_start = item.now_ms;
                           end else if (item.uplink_message_complete) begin
                              nxt.wait_kind = lssm_pkg::WK_NONE;
                              nxt.phase     = lssm_pkg::PH_ULDONE;
                              event_code    = lssm_pkg::EV_UL_DONE;
                           end
                        end else if (cur.last_type == lssm_pkg::TY_HEADER) begin
                           nxt.wait_kind = lssm_pkg::WK_NONE;
                           nxt.phase     = lssm_pkg::PH_ERROR;
                           event_code    = lssm_pkg::EV_UNEXP_HDR;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase

            // wait timer: retry or give up
            if (do_timer && timed_out) begin
               if (can_retry) begin
                  nxt.retry_count = cur.retry_count + 4'd1;
                  nxt.wait_start  = item.now_ms;
               end else begin
                  nxt.wait_kind = lssm_pkg::WK_NONE;
                  nxt.phase     = lssm_pkg::PH_ERROR;
                  event_code    = lssm_pkg::EV_TIMEOUT;
               end
            end
         end
         lssm_pkg::CMD_FRAME: begin
            nxt.last_type     = item.rx_type;
            nxt.last_status   = item.rx_status;
            nxt.last_frame_id = item.message_id;
            nxt.frame_pending = 1'b1;
            if (cur.wait_kind != lssm_pkg::WK_NONE) begin
               nxt.wait_start = item.now_ms;
            end
         end
         lssm_pkg::CMD_START_DL: begin
            nxt             = lssm_pkg::begin_wait(cur, lssm_pkg::WK_REQ, item.now_ms);
            nxt.downlink_id = item.message_id;
            nxt.phase       = lssm_pkg::PH_WAITREQ;
         end
         lssm_pkg::CMD_ABORT: begin
            nxt.wait_kind = lssm_pkg::WK_NONE;
            nxt.phase     = lssm_pkg::PH_ABORTED;
         end
         lssm_pkg::CMD_RESET: begin
            nxt = lssm_pkg::ctx_clear();
         end
         lssm_pkg::CMD_UL_OFFERED: begin
            if (cur.phase == lssm_pkg::PH_IDLE || cur.phase == lssm_pkg::PH_DLDONE ||
                cur.phase == lssm_pkg::PH_ABORTED || cur.phase == lssm_pkg::PH_ERROR ||
                cur.phase == lssm_pkg::PH_ULDONE) begin
               nxt       = lssm_pkg::begin_wait(cur, lssm_pkg::WK_ULHDR, item.now_ms);
               nxt.phase = lssm_pkg::PH_ULOFFER;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/link_session_state_machine_unit.sv @@
// An accepted item goes into the input register, then its result into the result register;
// a result-channel stall can hold it in between. Throughput: one item per cycle while the
// result channel does not stall, set by the single context register loop through lssm_core.
// Synchronous active-high reset clears the session context and the valid flags of both
// pipeline stages; timeout_ms resets to 2000 and max_retry to 3. Uses lssm_pkg and lssm_core.
`default_nettype none

module link_session_state_machine_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [7:0]  req_rx_type,
   input  wire logic [7:0]  req_rx_status,
   input  wire logic [31:0] req_message_id,
   input  wire logic        req_uplink_message_complete,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_session_state,
   output logic [3:0]       rsp_retries_used,
   output logic [2:0]       rsp_event_code,
   // configuration write port
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic                s1_valid_ff;
   lssm_pkg::item_type  s1_item_ff;
   lssm_pkg::item_type  s1_item_in;
   lssm_pkg::ctx_type   ctx_ff;
   lssm_pkg::ctx_type   ctx_in;
   logic [2:0]          event_in;
   logic [31:0]         timeout_ff;
   logic [3:0]          max_retry_ff;
   logic                rsp_valid_ff;
   logic [3:0]          state_ff;
   logic [3:0]          retries_ff;
   logic [2:0]          event_ff;
   logic                out_free;
   logic                advance;
   logic                accept;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_item_in.command                 = lssm_pkg::cmd_type'(req_command);
   assign s1_item_in.now_ms                  = req_now_ms;
   assign s1_item_in.rx_type                 = req_rx_type;
   assign s1_item_in.rx_status               = req_rx_status;
   assign s1_item_in.message_id              = req_message_id;
   assign s1_item_in.uplink_message_complete = req_uplink_message_complete;

   // session step logic
   lssm_core u_core (
      .cur        (ctx_ff),
      .item       (s1_item_ff),
      .timeout_ms (timeout_ff),
      .max_retry  (max_retry_ff),
      .nxt        (ctx_in),
      .event_code (event_in)
   );

   // control registers and session context
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctx_ff       <= lssm_pkg::ctx_clear();
         timeout_ff   <= lssm_pkg::TIMEOUT_RESET;
         max_retry_ff <= lssm_pkg::MAX_RETRY_RESET;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            ctx_ff       <= ctx_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               lssm_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata;
               lssm_pkg::CSR_MAX_RETRY: max_retry_ff <= csr_wdata[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
      if (advance) begin
         state_ff   <= lssm_pkg::phase_code(ctx_in.phase);
         retries_ff <= ctx_in.retry_count;
         event_ff   <= event_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_session_state = state_ff;
   assign rsp_retries_used  = retries_ff;
   assign rsp_event_code    = event_ff;

endmodule

`default_nettype wire

@@ rtl/lssm_checker.sv @@
// lssm_checker: port-level assertions for link_session_state_machine_unit
// bound to the top level below; uses only the top level's ports and lssm_pkg
`default_nettype none

module lssm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_session_state,
   input wire logic [3:0] rsp_retries_used,
   input wire logic [2:0] rsp_event_code
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_session_state) &&
         $stable(rsp_retries_used) && $stable(rsp_event_code))
      else $error("stalled result changed");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // failure events leave the session in error
   a_fail_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == lssm_pkg::EV_TIMEOUT ||
                    rsp_event_code == lssm_pkg::EV_STATUS_ERR ||
                    rsp_event_code == lssm_pkg::EV_HEADER_ERR ||
                    rsp_event_code == lssm_pkg::EV_UNEXP_HDR)
      |-> rsp_session_state == lssm_pkg::ST_ERROR)
      else $error("failure event without error state");

   // uplink complete event only with uplink done
   a_ul_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == lssm_pkg::EV_UL_DONE
      |-> rsp_session_state == lssm_pkg::ST_ULDONE)
      else $error("uplink complete event in wrong state");

endmodule

bind link_session_state_machine_unit lssm_checker u_lssm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_session_state (rsp_session_state),
   .rsp_retries_used  (rsp_retries_used),
   .rsp_event_code    (rsp_event_code)
);

`default_nettype wire
